[design/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, register indexes and byte helpers for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int CFG_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int LEN_WIDTH     = 5;
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_WIDTH = 8 * PATTERN_BYTES;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CASE_SENSITIVE = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_LOW    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PATTERN_HIGH   = 3'd4;

    // match modes
    localparam logic [1:0] MODE_FOUND     = 2'd0;
    localparam logic [1:0] MODE_NOT_FOUND = 2'd1;
    localparam logic [1:0] MODE_PASS_ALL  = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
    } text_item_t;

    typedef struct packed {
        logic line_passes;
        logic pattern_found;
    } result_item_t;

    // control shared by every cell of the window row
    typedef struct packed {
        logic                 shift;
        logic                 clear;
        logic                 exact;
        logic [LEN_WIDTH-1:0] len;
    } cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

[design/lsf_cell.sv]
// ----------------------------------------------------------------------------
// lsf_cell
// One window position: compares its byte against the aligned pattern byte and
// hands its byte and valid bit on to the next position, where there is one.
// ----------------------------------------------------------------------------
module lsf_cell #(
    parameter int INDEX    = 0,
    parameter bit HAS_NEXT = 1'b1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsf_pkg::cell_ctrl_t               ctrl,
    input  logic [lsf_pkg::PATTERN_WIDTH-1:0] pattern,
    input  logic [7:0]                        w_in,
    input  logic                              v_in,
    output logic [7:0]                        w_out,
    output logic                              v_out,
    output logic                              hit
);
    import lsf_pkg::*;

    logic                     active;
    logic [LEN_WIDTH-1:0]     sel;
    logic [PATTERN_WIDTH-1:0] shifted;
    logic [7:0]               pat_byte;

    // window position k lines up with pattern byte len-1-k
    always_comb
    begin
        active   = ctrl.len > LEN_WIDTH'(INDEX);
        sel      = ctrl.len - LEN_WIDTH'(INDEX) - LEN_WIDTH'(1);
        shifted  = pattern >> {sel[3:0], 3'b000};
        pat_byte = shifted[7:0];
        hit      = !active
                   || (v_in && (fold_byte(w_in, ctrl.exact) == fold_byte(pat_byte, ctrl.exact)));
    end

    generate
        if (HAS_NEXT)
        begin : g_store
            logic [7:0] w_reg;
            logic       v_reg;
            logic       v_next;

            always_comb
            begin
                v_next = v_reg;
                if (ctrl.clear)
                begin
                    v_next = 1'b0;
                end
                else if (ctrl.shift)
                begin
                    v_next = v_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else
                begin
                    v_reg <= v_next;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctrl.shift)
                begin
                    w_reg <= w_in;
                end
            end

            assign w_out = w_reg;
            assign v_out = v_reg;
        end
        else
        begin : g_last
            assign w_out = 8'h00;
            assign v_out = 1'b0;
        end
    endgenerate

endmodule

[design/line_substring_filter_unit.sv]
// result: the result of a line is offered in the cycle after its end-of-line item is accepted
// throughput: one item per cycle while no result is stalled, text bytes and end-of-line items alike
// the whole window is compared combinationally across the row of cells, one per pattern byte
// a waiting result stalls input only until it is taken
// reset: match mode pass-all, fold case, empty pattern, window and found flag clear
// ----------------------------------------------------------------------------
// line_substring_filter_unit
// Per-line substring filter over a byte stream with a sliding window of cells.
// ----------------------------------------------------------------------------
module line_substring_filter_unit #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              text_valid,
    output logic                              text_ready,
    input  lsf_pkg::text_item_t               text_item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output lsf_pkg::result_item_t             result_item,
    input  logic                              cfg_we,
    input  logic [lsf_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [lsf_pkg::CFG_WIDTH-1:0]     cfg_wdata
);
    import lsf_pkg::*;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = LEN_WIDTH'(PATTERN_MAX);

    logic [1:0]               match_mode_reg;
    logic                     case_sensitive_reg;
    logic [LEN_WIDTH-1:0]     pattern_length_reg;
    logic [PATTERN_WIDTH-1:0] pattern_reg;

    logic                     found_reg;
    logic                     found_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    result_item_t             result_item_reg;
    result_item_t             result_item_next;

    logic                     text_fire;
    logic                     byte_fire;
    logic                     eol_fire;
    logic [LEN_WIDTH-1:0]     len_eff;
    logic                     window_match;
    logic                     found_now;
    cell_ctrl_t               ctrl;

    logic [7:0]               w_chain [PATTERN_MAX];
    logic                     v_chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   hit;

    assign text_ready = !result_valid_reg || result_ready;
    assign text_fire  = text_valid && text_ready;
    assign byte_fire  = text_fire && !text_item.func;
    assign eol_fire   = text_fire && text_item.func;

    assign len_eff = (pattern_length_reg > LEN_MAX) ? LEN_MAX : pattern_length_reg;

    always_comb
    begin
        ctrl.shift = byte_fire;
        ctrl.clear = eol_fire;
        ctrl.exact = case_sensitive_reg;
        ctrl.len   = len_eff;
    end

    // the newest byte enters cell 0 directly and is always present
    assign w_chain[0] = text_item.text_byte;
    assign v_chain[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            if (k < PATTERN_MAX - 1)
            begin : g_mid
                lsf_cell #(
                    .INDEX    (k),
                    .HAS_NEXT (1'b1)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctrl    (ctrl),
                    .pattern (pattern_reg),
                    .w_in    (w_chain[k]),
                    .v_in    (v_chain[k]),
                    .w_out   (w_chain[k+1]),
                    .v_out   (v_chain[k+1]),
                    .hit     (hit[k])
                );
            end
            else
            begin : g_end
                lsf_cell #(
                    .INDEX    (k),
                    .HAS_NEXT (1'b0)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctrl    (ctrl),
                    .pattern (pattern_reg),
                    .w_in    (w_chain[k]),
                    .v_in    (v_chain[k]),
                    .w_out   (),
                    .v_out   (),
                    .hit     (hit[k])
                );
            end
        end
    endgenerate

    assign window_match = (len_eff != '0) && (&hit);
    assign found_now    = found_reg || (len_eff == '0);

    always_comb
    begin
        found_next = found_reg;
        if (eol_fire)
        begin
            found_next = 1'b0;
        end
        else if (byte_fire && window_match)
        begin
            found_next = 1'b1;
        end
    end

    always_comb
    begin
        result_item_next               = result_item_reg;
        result_item_next.pattern_found = found_now;
        case (match_mode_reg)
            MODE_FOUND:     result_item_next.line_passes = found_now;
            MODE_NOT_FOUND: result_item_next.line_passes = !found_now;
            MODE_PASS_ALL:  result_item_next.line_passes = 1'b1;
            default:        result_item_next.line_passes = 1'b1;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (eol_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_mode_reg     <= MODE_PASS_ALL;
            case_sensitive_reg <= 1'b0;
            pattern_length_reg <= '0;
            pattern_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATCH_MODE:     match_mode_reg          <= cfg_wdata[1:0];
                REG_CASE_SENSITIVE: case_sensitive_reg      <= cfg_wdata[0];
                REG_PATTERN_LENGTH: pattern_length_reg      <= cfg_wdata[LEN_WIDTH-1:0];
                REG_PATTERN_LOW:    pattern_reg[63:0]       <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_reg[127:64]     <= cfg_wdata;
                default:            match_mode_reg          <= match_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eol_fire)
        begin
            result_item_reg <= result_item_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

`ifndef SYNTHESIS
    // a finished line always starts the next one with a clear flag
    a_found_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        eol_fire |=> !found_reg)
        else $error("found flag not cleared at end of line");

    // text bytes never create a result
    a_no_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && !result_valid_reg) |=> !result_valid)
        else $error("result raised by a text byte");

    // empty pattern counts as found
    a_empty_found: assert property (@(posedge clk) disable iff (!rst_n)
        (eol_fire && len_eff == '0) |=> (result_valid && result_item.pattern_found))
        else $error("empty pattern not reported as found");

    // pass-all modes let every line through
    a_pass_all: assert property (@(posedge clk) disable iff (!rst_n)
        (eol_fire && match_mode_reg[1]) |=> result_item.line_passes)
        else $error("line blocked in pass-all mode");

    // a stalled result holds off new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !text_ready)
        else $error("item accepted while a result is stalled");
`endif

endmodule
